// File: rtl/psx_pkg.sv
// Package for the point sorter: shared control types.
// Used by psx_cell, psx_ctrl and point_sort_by_x_unit. No dependencies.
package psx_pkg;

  // Sequencer phases: collect points, then stream them out in order.
  typedef enum logic [0:0] {
    ST_LOAD  = 1'b0,
    ST_DRAIN = 1'b1
  } psx_state_t;

  // Command broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic insert;  // place the broadcast point at its sorted position
    logic drain;   // shift the whole chain one place toward cell zero
  } cell_ctl_t;

endpackage

// File: rtl/psx_cell.sv
// One cell of the sorting chain: holds one point and trades it with neighbors.
// Depends on psx_pkg for the cell command type.
module psx_cell import psx_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic                  occ,      // this cell holds a point of the set
  input  logic [COORD_BITS-1:0] new_x,
  input  logic [COORD_BITS-1:0] new_y,
  input  logic                  prev_ge,  // the cell before also gives way
  input  logic [COORD_BITS-1:0] prev_x,
  input  logic [COORD_BITS-1:0] prev_y,
  input  logic [COORD_BITS-1:0] next_x,
  input  logic [COORD_BITS-1:0] next_y,
  output logic                  ge,
  output logic [COORD_BITS-1:0] x,
  output logic [COORD_BITS-1:0] y
);

  logic [COORD_BITS-1:0] x_r, x_nxt;
  logic [COORD_BITS-1:0] y_r, y_nxt;

  // A cell gives way when it is empty or its key is not below the new key,
  // so a new point lands ahead of all equal keys.
  assign ge = !occ || (x_r >= new_x);
  assign x  = x_r;
  assign y  = y_r;

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (ctl.drain) begin
      x_nxt = next_x;
      y_nxt = next_y;
    end else if (ctl.insert && ge) begin
      if (prev_ge) begin
        x_nxt = prev_x;
        y_nxt = prev_y;
      end else begin
        x_nxt = new_x;
        y_nxt = new_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
  end

endmodule

// File: rtl/psx_ctrl.sv
// Sequencer of the point sorter: point count, overflow flag, load/drain phase.
// Depends on psx_pkg for the phase enum and the cell command type.
module psx_ctrl import psx_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int CNT_W      = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_last,
  input  logic             out_ready,
  output logic             in_ready,
  output logic             out_valid,
  output logic             out_last,
  output logic             ovf,
  output cell_ctl_t        ctl,
  output logic [CNT_W-1:0] count
);

  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

  psx_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    ctl        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (count_r != FULL) begin
            ctl.insert = 1'b1;
            count_nxt  = count_r + ONE;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        out_valid = 1'b1;
        if (out_ready) begin
          ctl.drain = 1'b1;
          count_nxt = count_r - ONE;
          if (count_r == ONE) begin
            state_nxt = ST_LOAD;
            ovf_nxt   = 1'b0;
          end
        end
      end
    endcase
  end

  assign out_last = (count_r == ONE);
  assign ovf      = ovf_r;
  assign count    = count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL) else $error("point count beyond capacity");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |-> count_r != '0) else $error("draining an empty set");

  a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD && in_valid && in_last) |=> state_r == ST_DRAIN)
    else $error("end of set did not start the drain");

  a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN && out_ready && count_r == ONE)
    |=> (state_r == ST_LOAD && count_r == '0 && !ovf_r))
    else $error("set not cleared after its final word");

  a_full_sets_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD && in_valid && count_r == FULL) |=> ovf_r)
    else $error("dropped point did not raise overflow");

endmodule

// File: rtl/point_sort_by_x_unit.sv
// Point sorter top level: input/output stream ports and the chain of cells.
// Depends on psx_pkg, psx_cell and psx_ctrl.
//
// Points enter one word per cycle and are placed at once into a chain of
// MAX_POINTS cells that stays sorted by x; each cell compares its key with
// the broadcast point and either keeps its point, takes the new one, or takes
// its neighbor's. The word marked tlast closes the set, and the next cycle the
// set streams out one word per cycle while out_tready is high, lowest x first,
// by shifting the chain toward cell zero, whose register drives the output
// directly. No input is taken while a set drains. Equal x values leave in
// reverse arrival order. Points that arrive when the chain is full are
// dropped and tuser (overflow) is set on every word of that set. No clearing
// pass is needed after reset.
module point_sort_by_x_unit import psx_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16,
  localparam int DATA_W    = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int CNT_W     = $clog2(MAX_POINTS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // point_x, point_y, zero padding
  input  logic              in_tlast,   // last_point
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // sorted_x, sorted_y, zero padding
  output logic              out_tlast,  // last_sorted
  output logic              out_tuser   // overflow
);

  cell_ctl_t             ctl;
  logic [CNT_W-1:0]      count;
  logic [COORD_BITS-1:0] new_x, new_y;
  logic [COORD_BITS-1:0] cell_x [MAX_POINTS];
  logic [COORD_BITS-1:0] cell_y [MAX_POINTS];
  logic [MAX_POINTS-1:0] cell_ge;

  assign new_x = in_tdata[COORD_BITS-1:0];
  assign new_y = in_tdata[2*COORD_BITS-1:COORD_BITS];

  psx_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_last   (in_tlast),
    .out_ready (out_tready),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_last  (out_tlast),
    .ovf       (out_tuser),
    .ctl       (ctl),
    .count     (count)
  );

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    logic                  prev_ge;
    logic [COORD_BITS-1:0] prev_x, prev_y, next_x, next_y;

    if (i == 0) begin : g_head
      assign prev_ge = 1'b0;
      assign prev_x  = '0;
      assign prev_y  = '0;
    end else begin : g_body
      assign prev_ge = cell_ge[i-1];
      assign prev_x  = cell_x[i-1];
      assign prev_y  = cell_y[i-1];
    end

    // The tail cell takes its own contents on a drain; after the shift it is past the count.
    if (i == MAX_POINTS - 1) begin : g_tail
      assign next_x = cell_x[i];
      assign next_y = cell_y[i];
    end else begin : g_link
      assign next_x = cell_x[i+1];
      assign next_y = cell_y[i+1];
    end

    psx_cell #(
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .occ     (count > CNT_W'(i)),
      .new_x   (new_x),
      .new_y   (new_y),
      .prev_ge (prev_ge),
      .prev_x  (prev_x),
      .prev_y  (prev_y),
      .next_x  (next_x),
      .next_y  (next_y),
      .ge      (cell_ge[i]),
      .x       (cell_x[i]),
      .y       (cell_y[i])
    );
  end

  assign out_tdata = DATA_W'({cell_y[0], cell_x[0]});

endmodule
